### design/linear_classifier_argmax_defines.svh
// Assertion macros for the linear classifier block.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef LINEAR_CLASSIFIER_ARGMAX_DEFINES_SVH
`define LINEAR_CLASSIFIER_ARGMAX_DEFINES_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset.
`define LCA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("linear_classifier_argmax: assertion failed");

// Checked on every clock edge, reset included.
`define LCA_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("linear_classifier_argmax: assertion failed");

`else

`define LCA_ASSERT(lbl, prop)
`define LCA_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

### design/lca_pkg.sv
// Shared types and constants of the linear classifier block.
// No dependencies.
package lca_pkg;

    localparam int PIXF_W = 10;   // weight_pixel field
    localparam int CLS_W  = 4;    // class index fields
    localparam int WVAL_W = 24;   // weight_value field
    localparam int PXV_W  = 8;    // pixel_value field
    localparam int ACC_W  = 48;   // accumulator and score width

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    typedef logic signed [ACC_W-1:0] t_score;

    typedef struct packed {
        logic                     command;
        logic [PIXF_W-1:0]        weight_pixel;
        logic [CLS_W-1:0]         weight_class;
        logic signed [WVAL_W-1:0] weight_value;
        logic [PXV_W-1:0]         pixel_value;
    } t_in;

    typedef struct packed {
        logic [CLS_W-1:0] predicted_class;
        t_score           best_score;
    } t_out;

endpackage

### design/lca_wmem.sv
// Weight memory for one class: one write port, one registered read port.
// Depends on nothing.
module lca_wmem #(
    parameter int DEPTH = 784,
    parameter int AW    = 10,
    parameter int DW    = 24
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic signed [DW-1:0] i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output logic signed [DW-1:0] o_rdata
);

    logic signed [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### design/lca_argmax.sv
// Registered comparison tree picking the highest score, lowest index on ties.
// Depends on lca_pkg.
module lca_argmax
    import lca_pkg::*;
#(
    parameter int NUM_CLASSES = 10
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_score i_score [NUM_CLASSES],
    output logic   o_valid,
    output t_out   o_best
);

    localparam int LVL    = $clog2(NUM_CLASSES);
    localparam int LEAVES = 1 << LVL;

    typedef struct packed {
        logic             present;
        logic [CLS_W-1:0] idx;
        t_score           score;
    } t_node;

    function automatic t_node pick(input t_node a, input t_node b);
        // left child always holds the lower indices, so it keeps ties
        if (b.present && (b.score > a.score)) begin
            return b;
        end
        return a;
    endfunction

    t_node            w_node [1:2*LEAVES-1];
    t_node            r_node [1:LEAVES-1];
    logic [LVL-1:0]   r_vld;

    for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
        if (k < NUM_CLASSES) begin : g_used
            assign w_node[LEAVES+k] = '{present: 1'b1, idx: CLS_W'(k), score: i_score[k]};
        end else begin : g_pad
            assign w_node[LEAVES+k] = '{present: 1'b0, idx: CLS_W'(k), score: '0};
        end
    end

    for (genvar i = 1; i < LEAVES; i++) begin : g_node
        always_ff @(posedge i_clk) begin
            r_node[i] <= pick(w_node[2*i], w_node[2*i+1]);
        end
        assign w_node[i] = r_node[i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (LVL > 1) begin
            r_vld <= {r_vld[LVL-2:0], i_valid};
        end else begin
            r_vld <= LVL'(i_valid);
        end
    end

    assign o_valid               = r_vld[LVL-1];
    assign o_best.predicted_class = w_node[1].idx;
    assign o_best.best_score      = w_node[1].score;

endmodule

### design/linear_classifier_argmax.sv
// Linear classifier with arg-max over NUM_CLASSES fixed-point scores.
// Depends on lca_pkg, lca_wmem, lca_argmax and linear_classifier_argmax_defines.svh.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): each request is either
// a weight load (command 0), written into the per-class weight memory at once,
// or the next pixel of the current image (command 1). Loads to an address
// outside NUM_PIXELS x NUM_CLASSES are dropped. One request is taken per cycle while o_in_ready is high.
// Each pixel reads its row of weights (registered memory read), multiplies it
// by the intensity in NUM_CLASSES parallel multipliers, and adds the products
// into the accumulators one stage later. After pixel NUM_PIXELS-1 the sums are
// copied to a snapshot, the accumulators clear, and the next image may follow
// in the next cycle. The snapshot runs through a registered comparison tree of
// $clog2(NUM_CLASSES) levels into a result FIFO.
// Path: a result passes the weight read, product, snapshot and tree registers
// and the result FIFO before it is offered on o_out_valid. Throughput: one
// request per cycle while o_in_ready is high.
// Stall: results queue in a FIFO of FIFO_DEPTH entries; o_in_ready drops only
// when that many results are owed to the receiver.
// Reset: accumulators, pixel position and all queues clear; the weight memory
// keeps its contents and must be loaded before use.
`include "linear_classifier_argmax_defines.svh"

module linear_classifier_argmax
    import lca_pkg::*;
#(
    parameter int NUM_PIXELS  = 784,
    parameter int NUM_CLASSES = 10,
    parameter int WEIGHT_BITS = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int PIX_W      = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
    localparam int PROD_W     = WEIGHT_BITS + PXV_W + 1;
    localparam int PIPE_LAT   = $clog2(NUM_CLASSES) + 4;
    localparam int FIFO_AW    = $clog2(PIPE_LAT + 1);
    localparam int FIFO_DEPTH = 1 << FIFO_AW;
    localparam int PEND_W     = FIFO_AW + 1;

    logic w_in_acc;
    logic w_out_acc;
    logic w_pixel;
    logic w_last;
    logic w_addr_ok;

    logic [PIX_W-1:0] r_pos;
    logic [PIX_W-1:0] n_pos;

    logic signed [WEIGHT_BITS-1:0] w_wdata;
    logic signed [WEIGHT_BITS-1:0] w_rdata [NUM_CLASSES];

    logic              r_s1_valid;
    logic              r_s1_last;
    logic [PXV_W-1:0]  r_s1_px;

    logic                    r_s2_valid;
    logic                    r_s2_last;
    logic signed [PROD_W-1:0] r_prod [NUM_CLASSES];

    t_score r_acc  [NUM_CLASSES];
    t_score n_sum  [NUM_CLASSES];
    t_score r_snap [NUM_CLASSES];
    logic   r_snap_valid;

    logic w_root_valid;
    t_out w_root;

    t_out               r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [PEND_W-1:0]  r_cnt;
    logic [PEND_W-1:0]  r_pend;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;
    assign w_pixel   = (i_in_data.command == CMD_PIXEL);
    assign w_last    = (r_pos == PIX_W'(NUM_PIXELS - 1));
    assign n_pos     = w_last ? '0 : r_pos + PIX_W'(1);
    assign w_addr_ok = (32'(i_in_data.weight_pixel) < NUM_PIXELS);
    assign w_wdata   = WEIGHT_BITS'($unsigned(i_in_data.weight_value));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_in_acc && w_pixel) begin
            r_pos <= n_pos;
        end
    end

    // one memory per class, all read at the current pixel position
    for (genvar k = 0; k < NUM_CLASSES; k++) begin : g_class
        lca_wmem #(
            .DEPTH (NUM_PIXELS),
            .AW    (PIX_W),
            .DW    (WEIGHT_BITS)
        ) u_wmem (
            .i_clk   (i_clk),
            .i_we    (w_in_acc && !w_pixel && w_addr_ok
                      && (i_in_data.weight_class == CLS_W'(k))),
            .i_waddr (PIX_W'(i_in_data.weight_pixel)),
            .i_wdata (w_wdata),
            .i_raddr (r_pos),
            .o_rdata (w_rdata[k])
        );

        always_ff @(posedge i_clk) begin
            r_prod[k] <= $signed({1'b0, r_s1_px}) * w_rdata[k];
        end

        assign n_sum[k] = r_acc[k] + ACC_W'(r_prod[k]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_acc[k] <= '0;
            end else if (r_s2_valid) begin
                r_acc[k] <= r_s2_last ? '0 : n_sum[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (r_s2_valid && r_s2_last) begin
                r_snap[k] <= n_sum[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_snap_valid <= 1'b0;
        end else begin
            r_s1_valid   <= w_in_acc && w_pixel;
            r_s2_valid   <= r_s1_valid;
            r_snap_valid <= r_s2_valid && r_s2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_px   <= i_in_data.pixel_value;
        r_s1_last <= w_last;
        r_s2_last <= r_s1_last;
    end

    lca_argmax #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_argmax (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_snap_valid),
        .i_score (r_snap),
        .o_valid (w_root_valid),
        .o_best  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (w_root_valid) begin
            r_fifo[r_wr_ptr] <= w_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
            r_pend   <= '0;
        end else begin
            if (w_root_valid) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (w_out_acc) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_cnt  <= r_cnt + PEND_W'(w_root_valid) - PEND_W'(w_out_acc);
            // count results owed: last pixels taken but not yet delivered
            r_pend <= r_pend + PEND_W'(w_in_acc && w_pixel && w_last)
                      - PEND_W'(w_out_acc);
        end
    end

    assign o_in_ready  = (r_pend < PEND_W'(FIFO_DEPTH));
    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_fifo[r_rd_ptr];

    `LCA_ASSERT(a_fifo_within_owed, r_cnt <= r_pend)
    `LCA_ASSERT(a_fifo_no_overflow, w_root_valid |-> (r_cnt < PEND_W'(FIFO_DEPTH)))
    `LCA_ASSERT(a_image_wrap, (w_in_acc && w_pixel && w_last) |=> (r_pos == '0))
    `LCA_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid)

endmodule
